/* rtl/core/wsfe_pkg.sv */
// wsfe_pkg: shared types and constants of the websocket client frame encoder
package wsfe_pkg;

	localparam int unsigned MaxPayloadDefault = 1024;
	localparam logic [31:0] SeedDefault = 32'h9e37_79b9;
	localparam int unsigned CfgAddrWidth = 3;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_TOO_LONG = 2'd1,
		ST_NO_FRAME = 2'd2
	} status_t;

	typedef enum logic {
		MODE_START   = 1'b0,
		MODE_PAYLOAD = 1'b1
	} mode_t;

	typedef enum logic [0:0] {
		REG_MASK_SEED = 1'b0
	} reg_idx_t;

	typedef struct packed {
		logic        load;
		logic [31:0] word;
	} seed_load_t;

endpackage

/* rtl/core/wsfe_ifs.sv */
// wsfe_ifs: valid/ready channel interfaces for input items and result bytes
interface wsfe_in_if;
	logic        valid;
	logic        ready;
	logic        mode;
	logic [3:0]  frame_opcode;
	logic [15:0] frame_length;
	logic [7:0]  payload_byte;

	modport source (output valid, output mode, output frame_opcode, output frame_length,
		output payload_byte, input ready);
	modport sink (input valid, input mode, input frame_opcode, input frame_length,
		input payload_byte, output ready);
endinterface

interface wsfe_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       run_last;
	logic       frame_end;
	logic [1:0] status;

	modport source (output valid, output out_byte, output run_last, output frame_end,
		output status, input ready);
	modport sink (input valid, input out_byte, input run_last, input frame_end,
		input status, output ready);
endinterface

/* rtl/core/wsfe_apb_regs.sv */
// wsfe_apb_regs: apb register port holding the mask seed
module wsfe_apb_regs (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   psel,
	input  logic                                   penable,
	input  logic                                   pwrite,
	input  logic [wsfe_pkg::CfgAddrWidth-1:0]      paddr,
	input  logic [31:0]                            pwdata,
	output logic [31:0]                            prdata,
	output logic                                   pready,
	output wsfe_pkg::seed_load_t                   seed_load
);

	logic [31:0] mask_seed_q;
	logic        hit;
	logic        wr;

	assign hit    = (paddr[wsfe_pkg::CfgAddrWidth-1] == wsfe_pkg::REG_MASK_SEED);
	assign wr     = psel && penable && pwrite && hit;
	assign pready = 1'b1;
	assign prdata = hit ? mask_seed_q : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_seed_q <= wsfe_pkg::SeedDefault;
		end else if (wr) begin
			mask_seed_q <= pwdata;
		end
	end

	// zero seed would stick the generator
	assign seed_load.load = wr;
	assign seed_load.word = (pwdata == 32'd0) ? wsfe_pkg::SeedDefault : pwdata;

endmodule

/* rtl/core/websocket_client_frame_encoder_unit.sv */
// websocket_client_frame_encoder_unit: masked client websocket frame encoder, top level
//
//  channel  | dir | transaction
//  ---------+-----+-------------------------------------------------------------
//  in_ch    | in  | mode, frame_opcode, frame_length, payload_byte
//  out_ch   | out | out_byte, run_last, frame_end, status
//  apb      | in  | mask_seed write/read at byte addresses 0 to 3
//
//  a payload item, a rejected start or an orphan payload byte yields one result
//  an accepted start yields 6 header bytes (length below 126) or 8, one header
//  byte per cycle unless out_ch stalls, from the header sequencer in the item stage
//  out_ch ready low holds the output register and stalls the item stage
//  reset clears all control and frame state and loads the default seed
module websocket_client_frame_encoder_unit #(
	parameter int unsigned MAX_PAYLOAD = wsfe_pkg::MaxPayloadDefault
) (
	input  logic                              clk,
	input  logic                              arst_n,
	wsfe_in_if.sink                           in_ch,
	wsfe_out_if.source                        out_ch,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [wsfe_pkg::CfgAddrWidth-1:0] paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready
);

	localparam logic [15:0] MaxLen = 16'(MAX_PAYLOAD);

	function automatic logic [31:0] xs_step(input logic [31:0] w);
		logic [31:0] x;
		x = w;
		x = x ^ (x << 13);
		x = x ^ (x >> 17);
		x = x ^ (x << 5);
		return x;
	endfunction

	wsfe_pkg::seed_load_t seed_load;

	wsfe_apb_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.seed_load (seed_load)
	);

	// item stage
	logic        vld_s1;
	logic        mode_s1;
	logic [3:0]  opc_s1;
	logic [15:0] len_s1;
	logic [7:0]  pb_s1;
	logic [2:0]  idx_q;

	// frame state
	logic [31:0] prng_q;
	logic [7:0]  mask_q [4];
	logic [15:0] left_q;
	logic [1:0]  pos_q;
	logic        open_q;

	// output register
	logic        out_vld_q;
	logic [7:0]  out_byte_q;
	logic        out_last_q;
	logic        out_end_q;
	logic [1:0]  out_st_q;

	logic        emit;
	logic        retire;
	logic        is_start;
	logic        too_long;
	logic        ext;
	logic [2:0]  last_idx;
	logic [1:0]  mask_k;
	logic        is_mask;
	logic [31:0] step;
	logic [7:0]  nx_byte;
	logic        nx_last;
	logic        nx_end;
	wsfe_pkg::status_t nx_st;

	assign emit        = vld_s1 && (!out_vld_q || out_ch.ready);
	assign retire      = emit && nx_last;
	assign in_ch.ready = !vld_s1 || retire;

	assign is_start = (mode_s1 == wsfe_pkg::MODE_START);
	assign too_long = (len_s1 > MaxLen);
	assign ext      = (len_s1 >= 16'd126);
	assign last_idx = ext ? 3'd7 : 3'd5;
	assign mask_k   = ext ? 2'(idx_q - 3'd4) : 2'(idx_q - 3'd2);
	assign is_mask  = ext ? (idx_q >= 3'd4) : (idx_q >= 3'd2);
	assign step     = xs_step(prng_q);

	always_comb begin
		nx_byte = 8'd0;
		nx_last = 1'b1;
		nx_end  = 1'b0;
		nx_st   = wsfe_pkg::ST_OK;
		if (is_start) begin
			if (too_long) begin
				nx_st = wsfe_pkg::ST_TOO_LONG;
			end else begin
				nx_last = (idx_q == last_idx);
				nx_end  = nx_last && (len_s1 == 16'd0);
				if (is_mask) begin
					nx_byte = step[7:0];
				end else begin
					case (idx_q)
						3'd0: nx_byte = {4'h8, opc_s1};
						3'd1: nx_byte = ext ? 8'd254 : {1'b1, len_s1[6:0]};
						3'd2: nx_byte = len_s1[15:8];
						3'd3: nx_byte = len_s1[7:0];
						default: nx_byte = 8'd0;
					endcase
				end
			end
		end else if (!open_q) begin
			nx_st = wsfe_pkg::ST_NO_FRAME;
		end else begin
			nx_byte = pb_s1 ^ mask_q[pos_q];
			nx_end  = (left_q == 16'd1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			idx_q  <= 3'd0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				vld_s1 <= 1'b1;
			end else if (retire) begin
				vld_s1 <= 1'b0;
			end
			if (retire) begin
				idx_q <= 3'd0;
			end else if (emit) begin
				idx_q <= idx_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			mode_s1 <= in_ch.mode;
			opc_s1  <= in_ch.frame_opcode;
			len_s1  <= in_ch.frame_length;
			pb_s1   <= in_ch.payload_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prng_q <= wsfe_pkg::SeedDefault;
			for (int i = 0; i < 4; i++) begin
				mask_q[i] <= 8'd0;
			end
			left_q <= 16'd0;
			pos_q  <= 2'd0;
			open_q <= 1'b0;
		end else if (seed_load.load) begin
			prng_q <= seed_load.word;
		end else if (emit && nx_st == wsfe_pkg::ST_OK) begin
			if (is_start) begin
				if (is_mask) begin
					prng_q         <= step;
					mask_q[mask_k] <= step[7:0];
				end
				if (nx_last) begin
					left_q <= len_s1;
					pos_q  <= 2'd0;
					open_q <= (len_s1 != 16'd0);
				end
			end else begin
				left_q <= left_q - 16'd1;
				pos_q  <= pos_q + 2'd1;
				open_q <= (left_q != 16'd1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (emit) begin
			out_vld_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q <= nx_byte;
			out_last_q <= nx_last;
			out_end_q  <= nx_end;
			out_st_q   <= nx_st;
		end
	end

	assign out_ch.valid     = out_vld_q;
	assign out_ch.out_byte  = out_byte_q;
	assign out_ch.run_last  = out_last_q;
	assign out_ch.frame_end = out_end_q;
	assign out_ch.status    = out_st_q;

endmodule

/* rtl/core/wsfe_checker.sv */
// wsfe_checker: port-level assertions for the frame encoder, with bind
module wsfe_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       run_last,
	input logic       frame_end,
	input logic [1:0] status
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_byte) && $stable(status)
			&& $stable(run_last) && $stable(frame_end))
		else $error("stalled result changed");

	a_err_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != wsfe_pkg::ST_OK |->
			run_last && !frame_end && out_byte == 8'd0)
		else $error("error result malformed");

	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_end |-> run_last)
		else $error("frame end not on last result");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status == wsfe_pkg::ST_OK || status == wsfe_pkg::ST_TOO_LONG
			|| status == wsfe_pkg::ST_NO_FRAME)
		else $error("undefined status code");

endmodule

bind websocket_client_frame_encoder_unit wsfe_checker u_wsfe_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_byte  (out_ch.out_byte),
	.run_last  (out_ch.run_last),
	.frame_end (out_ch.frame_end),
	.status    (out_ch.status)
);

/* tb/sv/wsfe_frame_checker.sv */
// wsfe_frame_checker: predicts masked frame bytes and checks every output transaction
`timescale 1ns / 100ps
module wsfe_frame_checker #(
	parameter int unsigned MAX_PAYLOAD = wsfe_pkg::MaxPayloadDefault
) (
	input  logic                              clk,
	input  logic                              arst_n,
	wsfe_in_if                                in_mon,
	wsfe_out_if                               out_mon,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [wsfe_pkg::CfgAddrWidth-1:0] paddr,
	input  logic [31:0]                       pwdata,
	input  logic                              pready,
	output int unsigned                       mismatches,
	output int unsigned                       pending
);
	localparam int unsigned PRINT_CAP = 40;
	localparam logic [wsfe_pkg::CfgAddrWidth-1:0] SEED_ADDR = {wsfe_pkg::REG_MASK_SEED, 2'b00};
	localparam logic [7:0] FIN_BIT = 8'h80;
	localparam logic [7:0] MASK_BIT = 8'h80;
	localparam logic [6:0] LEN_EXT16 = 7'd126;

	typedef struct packed {
		logic [7:0]        out_byte;
		logic              run_last;
		logic              frame_end;
		wsfe_pkg::status_t status;
	} wire_byte_t;

	wire_byte_t  wire_bytes_q [$];
	wire_byte_t  want;
	logic [31:0] xs_word;
	logic [7:0]  mask_key [4];
	logic [15:0] remaining;
	logic [1:0]  key_pos;
	logic        in_frame;

	function automatic logic [31:0] xorshift32(input logic [31:0] x);
		logic [31:0] y;
		y = x ^ (x << 13);
		y = y ^ (y >> 17);
		y = y ^ (y << 5);
		return y;
	endfunction

	task automatic report_mismatch(input string what, input logic [7:0] got,
		input logic [7:0] exp_val);
		if (mismatches < PRINT_CAP) begin
			$display("%0t: %s: got 0x%0h, expected 0x%0h", $realtime, what, got, exp_val);
		end
		mismatches++;
	endtask

	task automatic queue_wire_byte(input logic [7:0] b, input logic last, input logic fend,
		input wsfe_pkg::status_t st);
		wire_bytes_q.push_back('{out_byte: b, run_last: last, frame_end: fend, status: st});
	endtask

	task automatic encode_item(input wsfe_pkg::mode_t mode, input logic [3:0] opc,
		input logic [15:0] len, input logic [7:0] pb);
		logic [7:0] hdr [$];
		if (mode == wsfe_pkg::MODE_START && len > MAX_PAYLOAD) begin
			queue_wire_byte(8'h00, 1'b1, 1'b0, wsfe_pkg::ST_TOO_LONG);
		end else if (mode == wsfe_pkg::MODE_START) begin
			hdr.push_back(FIN_BIT | {4'h0, opc});
			if (len < LEN_EXT16) begin
				hdr.push_back(MASK_BIT | {1'b0, len[6:0]});
			end else begin
				hdr.push_back(MASK_BIT | {1'b0, LEN_EXT16});
				hdr.push_back(len[15:8]);
				hdr.push_back(len[7:0]);
			end
			for (int i = 0; i < 4; i++) begin
				xs_word = xorshift32(xs_word);
				mask_key[i] = xs_word[7:0];
				hdr.push_back(mask_key[i]);
			end
			for (int i = 0; i < hdr.size(); i++) begin
				queue_wire_byte(hdr[i], i == hdr.size() - 1,
					(i == hdr.size() - 1) && (len == 16'd0), wsfe_pkg::ST_OK);
			end
			remaining = len;
			key_pos = 2'd0;
			in_frame = (len != 16'd0);
		end else if (!in_frame) begin
			queue_wire_byte(8'h00, 1'b1, 1'b0, wsfe_pkg::ST_NO_FRAME);
		end else begin
			remaining = remaining - 16'd1;
			in_frame = (remaining != 16'd0);
			queue_wire_byte(pb ^ mask_key[key_pos], 1'b1, remaining == 16'd0, wsfe_pkg::ST_OK);
			key_pos = key_pos + 2'd1;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wire_bytes_q.delete();
			xs_word = wsfe_pkg::SeedDefault;
			mask_key = '{default: 8'h00};
			remaining = '0;
			key_pos = '0;
			in_frame = 1'b0;
			mismatches = 0;
			pending = 0;
		end else begin
			if (out_mon.valid && out_mon.ready) begin
				if (wire_bytes_q.size() == 0) begin
					report_mismatch("result with nothing pending", out_mon.out_byte, 8'h00);
				end else begin
					want = wire_bytes_q.pop_front();
					if (out_mon.out_byte !== want.out_byte) begin
						report_mismatch("out_byte", out_mon.out_byte, want.out_byte);
					end
					if (out_mon.run_last !== want.run_last) begin
						report_mismatch("run_last", {7'd0, out_mon.run_last}, {7'd0, want.run_last});
					end
					if (out_mon.frame_end !== want.frame_end) begin
						report_mismatch("frame_end", {7'd0, out_mon.frame_end},
							{7'd0, want.frame_end});
					end
					if (out_mon.status !== want.status) begin
						report_mismatch("status", {6'd0, out_mon.status}, {6'd0, want.status});
					end
				end
			end
			if (psel && penable && pwrite && pready && paddr == SEED_ADDR) begin
				xs_word = (pwdata != 32'd0) ? pwdata : wsfe_pkg::SeedDefault;
			end
			if (in_mon.valid && in_mon.ready) begin
				encode_item(wsfe_pkg::mode_t'(in_mon.mode), in_mon.frame_opcode,
					in_mon.frame_length, in_mon.payload_byte);
			end
			pending = wire_bytes_q.size();
		end
	end

endmodule

/* tb/sv/tb_top.sv */
// tb_top: stimulus, handshake pacing and verdict for the websocket client frame encoder
`timescale 1ns / 100ps
module tb_top;

	localparam int unsigned MAX_PAYLOAD = wsfe_pkg::MaxPayloadDefault;
	localparam int unsigned ITEMS_PER_PHASE = 55;
	localparam int unsigned HOLD_OFF_CYCLES = 200;
	localparam int unsigned WATCHDOG_LIMIT = 2000;
	localparam int unsigned DRAIN_CYCLES = 16;
	localparam logic [wsfe_pkg::CfgAddrWidth-1:0] SEED_ADDR = {wsfe_pkg::REG_MASK_SEED, 2'b00};

	logic                              clk = 1'b0;
	logic                              arst_n;
	logic                              psel;
	logic                              penable;
	logic                              pwrite;
	logic [wsfe_pkg::CfgAddrWidth-1:0] paddr;
	logic [31:0]                       pwdata;
	logic [31:0]                       prdata;
	logic                              pready;
	int unsigned                       mismatches;
	int unsigned                       pending;
	int unsigned                       src_idle_pct;
	int unsigned                       snk_idle_pct;
	int unsigned                       items_sent;
	int unsigned                       idle_cycles;
	logic                              hold_armed;
	logic                              hold_served;
	logic [31:0]                       phase_seed [4];

	wsfe_in_if  in_ch ();
	wsfe_out_if out_ch ();

	websocket_client_frame_encoder_unit #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready)
	);

	wsfe_frame_checker #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_frame_chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_mon    (in_ch),
		.out_mon   (out_ch),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.pready    (pready),
		.mismatches(mismatches),
		.pending   (pending)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	task automatic drive_item(input wsfe_pkg::mode_t mode, input logic [3:0] opc,
		input logic [15:0] len, input logic [7:0] pb);
		while ($urandom_range(99) < src_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.mode <= mode;
		in_ch.frame_opcode <= opc;
		in_ch.frame_length <= len;
		in_ch.payload_byte <= pb;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		@(negedge clk);
		items_sent++;
	endtask

	task automatic send_start(input logic [3:0] opc, input logic [15:0] len);
		drive_item(wsfe_pkg::MODE_START, opc, len, 8'($urandom_range(255)));
	endtask

	task automatic send_byte(input logic [7:0] pb);
		drive_item(wsfe_pkg::MODE_PAYLOAD, 4'($urandom_range(15)), 16'($urandom), pb);
	endtask

	task automatic send_random_frame();
		int unsigned pick;
		int unsigned len;
		int unsigned nbytes;
		pick = $urandom_range(99);
		if (pick < 45) len = $urandom_range(8);
		else if (pick < 60) len = $urandom_range(125, 9);
		else if (pick < 75) len = $urandom_range(140, 126);
		else if (pick < 85) len = $urandom_range(MAX_PAYLOAD, 141);
		else if (pick < 90) len = MAX_PAYLOAD;
		else len = $urandom_range(65535, MAX_PAYLOAD + 1);
		if (len <= 16 && $urandom_range(7) != 0) nbytes = len;
		else if (len >= 126 && len <= 140 && $urandom_range(5) == 0) nbytes = len;
		else nbytes = $urandom_range(len < 6 ? len : 6);
		send_start(4'($urandom_range(15)), 16'(len));
		repeat (nbytes) send_byte(8'($urandom_range(255)));
		// stray bytes: orphan after a closed frame, continuation of an open one
		if ($urandom_range(9) == 0) send_byte(8'($urandom_range(255)));
	endtask

	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	task automatic write_seed(input logic [31:0] seed);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= SEED_ADDR;
		pwdata <= seed;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	initial begin
		out_ch.ready = 1'b0;
		hold_served = 1'b0;
		@(negedge clk);
		forever begin
			if (hold_armed && !hold_served) begin
				hold_served = 1'b1;
				out_ch.ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(negedge clk);
			end else begin
				out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
				@(negedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_ch.valid = 1'b0;
		in_ch.mode = wsfe_pkg::MODE_START;
		in_ch.frame_opcode = '0;
		in_ch.frame_length = '0;
		in_ch.payload_byte = '0;
		src_idle_pct = 15;
		snk_idle_pct = 50;
		hold_armed = 1'b0;
		items_sent = 0;
		phase_seed[0] = 32'h0000_0001;
		phase_seed[1] = 32'hFFFF_FFFF;
		phase_seed[2] = 32'h0000_0000;
		phase_seed[3] = $urandom;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		send_byte(8'hFF);
		send_start(4'h0, 16'd0);
		send_byte(8'h00);
		send_start(4'h1, 16'd3);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'hA5);
		send_start(4'h2, 16'd126);
		send_byte(8'h5A);
		send_byte(8'hC3);
		send_start(4'h8, 16'(MAX_PAYLOAD));
		send_byte(8'h81);
		send_byte(8'h7E);
		send_start(4'hF, 16'(MAX_PAYLOAD + 1));
		send_byte(8'h3C);
		send_start(4'h9, 16'hFFFF);
		send_start(4'hA, 16'd125);
		send_start(4'h7, 16'd1);
		send_byte(8'h96);

		for (int p = 0; p < 4; p++) begin
			wait_drained();
			write_seed(phase_seed[p]);
			src_idle_pct = (p == 0) ? 15 : (p == 1) ? 50 : 0;
			snk_idle_pct = (p == 0) ? 50 : (p == 1) ? 15 : 0;
			hold_armed = (p == 2);
			items_sent = 0;
			while (items_sent < ITEMS_PER_PHASE) send_random_frame();
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

/* sim.f */
rtl/core/wsfe_pkg.sv
rtl/core/wsfe_ifs.sv
rtl/core/wsfe_apb_regs.sv
rtl/core/websocket_client_frame_encoder_unit.sv
rtl/core/wsfe_checker.sv
tb/sv/wsfe_frame_checker.sv
tb/sv/tb_top.sv
